>>> rtl/sla_pkg.sv
// Shared types and constants for the seam linear alpha blend block.
// Used by every module under rtl/.
package sla_pkg;

  localparam int CHANNELS      = 3;
  localparam int CHAN_W        = 8;
  localparam int COL_W         = 12;
  localparam int LW_W          = 13;
  localparam int MAX_WIDTH_DEF = 4096;

  localparam int QBITS       = CHAN_W;
  localparam int LANE_STAGES = QBITS + 2;
  localparam int PIPE_STAGES = LANE_STAGES + 2;
  localparam int PROD_W      = 22;
  localparam int NUM_W       = PROD_W + 1;
  localparam int MAG_W       = NUM_W - 2;
  localparam int REM_W       = COL_W + QBITS;

  localparam int IN_FIELDS_W = COL_W + 3 * CHANNELS * CHAN_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = CHANNELS * CHAN_W;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLAP_START = 2'd0,
    CFG_OVERLAP_END   = 2'd1,
    CFG_LEFT_WIDTH    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [COL_W:0] w;
    logic [COL_W-1:0]      absw;
    logic                  wneg;
  } geom_t;

  typedef struct packed {
    logic [QBITS-1:0]  q;
    logic              zero;
    logic              sat;
    logic [CHAN_W-1:0] left;
    logic [CHAN_W-1:0] stitched;
  } lane_res_t;

endpackage

>>> rtl/sla_front.sv
// Region decode and blend geometry for one pixel.
// Depends on sla_pkg.
module sla_front #(
  parameter int MAX_WIDTH = sla_pkg::MAX_WIDTH_DEF
) (
  input  logic [sla_pkg::COL_W-1:0]  overlap_start,
  input  logic [sla_pkg::COL_W-1:0]  overlap_end,
  input  logic [sla_pkg::LW_W-1:0]   left_width,
  input  logic [sla_pkg::COL_W-1:0]  column,
  input  logic [sla_pkg::CHAN_W-1:0] right_px [sla_pkg::CHANNELS],
  output sla_pkg::mode_t             mode,
  output logic [sla_pkg::COL_W-1:0]  col_off,
  output sla_pkg::geom_t             geom
);
  import sla_pkg::*;

  localparam logic [31:0] MAXW = 32'(MAX_WIDTH);

  logic              in_region;
  logic              black;
  logic signed [COL_W:0] w;

  always_comb begin
    w         = $signed({1'b0, overlap_end}) - $signed({1'b0, overlap_start});
    geom.w    = w;
    geom.wneg = w[COL_W];
    geom.absw = w[COL_W] ? COL_W'(-w) : COL_W'(w);
    col_off   = column - overlap_start;
    in_region = (column >= overlap_start) && ({1'b0, column} < left_width)
                && (32'(column) < MAXW);
    black = 1'b1;
    for (int k = 0; k < CHANNELS; k++) begin
      if (right_px[k] != '0) black = 1'b0;
    end
    if (!in_region) begin
      mode = MODE_PASS;
    end else if (black || overlap_end == overlap_start) begin
      mode = MODE_LEFT;
    end else begin
      mode = MODE_BLEND;
    end
  end

endmodule

>>> rtl/sla_lane.sv
// One color channel: weighted sum, then a pipelined restoring divide, one quotient bit a stage.
// Depends on sla_pkg.
module sla_lane (
  input  logic                             clk,
  input  logic [sla_pkg::LANE_STAGES-1:0]  en,
  input  sla_pkg::geom_t                   geom,
  input  logic [sla_pkg::COL_W-1:0]        col_off,
  input  logic [sla_pkg::CHAN_W-1:0]       left_px,
  input  logic [sla_pkg::CHAN_W-1:0]       right_px,
  input  logic [sla_pkg::CHAN_W-1:0]       stitched_px,
  output sla_pkg::lane_res_t               res
);
  import sla_pkg::*;

  logic signed [PROD_W-1:0] p1, p2;
  logic [CHAN_W-1:0]        l1, s1;
  logic signed [CHAN_W:0]   diff;
  logic signed [COL_W:0]    dd;

  logic signed [NUM_W-1:0]  sum, numc;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         lim;

  logic [REM_W-1:0]  rem  [0:QBITS];
  logic [QBITS-1:0]  quo  [0:QBITS];
  logic              zf   [0:QBITS];
  logic              sf   [0:QBITS];
  logic [CHAN_W-1:0] lv   [0:QBITS];
  logic [CHAN_W-1:0] sv   [0:QBITS];

  always_comb begin
    diff = $signed({1'b0, right_px}) - $signed({1'b0, left_px});
    dd   = $signed({1'b0, col_off});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= $signed({1'b0, left_px}) * geom.w;
      p2 <= diff * dd;
      l1 <= left_px;
      s1 <= stitched_px;
    end
  end

  always_comb begin
    sum  = NUM_W'(p1) + NUM_W'(p2);
    numc = geom.wneg ? -sum : sum;
    mag  = numc[MAG_W-1:0];
    lim  = MAG_W'({geom.absw, {QBITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0] <= mag[REM_W-1:0];
      quo[0] <= '0;
      zf[0]  <= (numc <= 0);
      sf[0]  <= (mag >= lim);
      lv[0]  <= l1;
      sv[0]  <= s1;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int K = QBITS - 1 - j;
    logic [REM_W-1:0] trial;
    logic             fits;

    always_comb begin
      trial = REM_W'(geom.absw) << K;
      fits  = rem[j] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        rem[j+1] <= fits ? rem[j] - trial : rem[j];
        quo[j+1] <= quo[j] | (QBITS'(fits) << K);
        zf[j+1]  <= zf[j];
        sf[j+1]  <= sf[j];
        lv[j+1]  <= lv[j];
        sv[j+1]  <= sv[j];
      end
    end
  end

  always_comb begin
    res.q        = quo[QBITS];
    res.zero     = zf[QBITS];
    res.sat      = sf[QBITS];
    res.left     = lv[QBITS];
    res.stitched = sv[QBITS];
  end

endmodule

>>> rtl/sla_merge.sv
// Output stage: picks each channel's value from its lane and registers the result item.
// Depends on sla_pkg.
module sla_merge (
  input  logic                        clk,
  input  logic                        load,
  input  sla_pkg::mode_t              mode,
  input  sla_pkg::lane_res_t          res [sla_pkg::CHANNELS],
  output logic [sla_pkg::OUT_TDATA_W-1:0] tdata,
  output logic                        blended
);
  import sla_pkg::*;

  logic [OUT_TDATA_W-1:0] tdata_next;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      case (mode)
        MODE_PASS:  tdata_next[k*CHAN_W +: CHAN_W] = res[k].stitched;
        MODE_LEFT:  tdata_next[k*CHAN_W +: CHAN_W] = res[k].left;
        MODE_BLEND: begin
          if (res[k].zero) begin
            tdata_next[k*CHAN_W +: CHAN_W] = '0;
          end else if (res[k].sat) begin
            tdata_next[k*CHAN_W +: CHAN_W] = '1;
          end else begin
            tdata_next[k*CHAN_W +: CHAN_W] = res[k].q;
          end
        end
        default:    tdata_next[k*CHAN_W +: CHAN_W] = res[k].stitched;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata   <= tdata_next;
      blended <= (mode != MODE_PASS);
    end
  end

endmodule

>>> rtl/seam_linear_alpha_blend_top.sv
// Top level of the seam linear alpha blend: register file, input stage, three channel lanes
// and the output stage. Depends on sla_pkg, sla_front, sla_lane and sla_merge.
//
// Usage:
//   s_axis carries one pixel per item: column, left RGB, right RGB and current stitched RGB.
//   m_axis returns one item per pixel: blended RGB in tdata, the blended flag in tuser.
//   cfg writes overlap_start (index 0), overlap_end (1) and left_width (2); other indexes
//   are ignored. cfg_ready is always high; write only while no pixel is in flight.
// Timing:
//   A pixel travels from the accepting edge to m_axis_tvalid through a 12-stage
//   pipeline: input register, product stage, numerator stage, eight restoring divide
//   stages (one quotient bit each), output register. Throughput is one pixel per clock
//   while m_axis_tready is high. The three color channels run in parallel lanes.
// Reset:
//   rst (synchronous) empties the pipeline and clears all three registers to zero.
// Stalls:
//   When m_axis_tready is low the output item holds; earlier stages keep filling any
//   bubbles, so s_axis_tready drops only once every stage holds an item.
module seam_linear_alpha_blend_top #(
  parameter int MAX_WIDTH = sla_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // column, left_red, left_green, left_blue, right_red, right_green, right_blue,
  // stitched_red, stitched_green, stitched_blue
  input  logic [sla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red, out_green, out_blue
  output logic [sla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // was_blended
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sla_pkg::LW_W-1:0]          cfg_data
);
  import sla_pkg::*;

  localparam int NS = PIPE_STAGES;

  logic [COL_W-1:0]  overlap_start, overlap_end;
  logic [LW_W-1:0]   left_width;

  logic [NS-1:0]     v;
  logic [NS-1:0]     free;

  logic [COL_W-1:0]  col0;
  logic [CHAN_W-1:0] l0 [CHANNELS];
  logic [CHAN_W-1:0] r0 [CHANNELS];
  logic [CHAN_W-1:0] s0 [CHANNELS];

  mode_t             mode_f;
  logic [COL_W-1:0]  col_off;
  geom_t             geom;
  mode_t             mode_q [0:LANE_STAGES-1];
  lane_res_t         res [CHANNELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_start <= '0;
      overlap_end   <= '0;
      left_width    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OVERLAP_START: overlap_start <= cfg_data[COL_W-1:0];
        CFG_OVERLAP_END:   overlap_end   <= cfg_data[COL_W-1:0];
        CFG_LEFT_WIDTH:    left_width    <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_comb begin
    free[NS-1] = !v[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      free[i] = !v[i] || free[i+1];
    end
  end

  assign s_axis_tready = free[0];
  assign m_axis_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (free[0]) v[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (free[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      col0 <= s_axis_tdata[COL_W-1:0];
      for (int k = 0; k < CHANNELS; k++) begin
        l0[k] <= s_axis_tdata[COL_W + k*CHAN_W +: CHAN_W];
        r0[k] <= s_axis_tdata[COL_W + (CHANNELS + k)*CHAN_W +: CHAN_W];
        s0[k] <= s_axis_tdata[COL_W + (2*CHANNELS + k)*CHAN_W +: CHAN_W];
      end
    end
  end

  sla_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .overlap_start (overlap_start),
    .overlap_end   (overlap_end),
    .left_width    (left_width),
    .column        (col0),
    .right_px      (r0),
    .mode          (mode_f),
    .col_off       (col_off),
    .geom          (geom)
  );

  always_ff @(posedge clk) begin
    if (free[1]) mode_q[0] <= mode_f;
    for (int i = 1; i < LANE_STAGES; i++) begin
      if (free[i+1]) mode_q[i] <= mode_q[i-1];
    end
  end

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    sla_lane u_lane (
      .clk         (clk),
      .en          (free[LANE_STAGES:1]),
      .geom        (geom),
      .col_off     (col_off),
      .left_px     (l0[k]),
      .right_px    (r0[k]),
      .stitched_px (s0[k]),
      .res         (res[k])
    );
  end

  sla_merge u_merge (
    .clk     (clk),
    .load    (free[NS-1]),
    .mode    (mode_q[LANE_STAGES-1]),
    .res     (res),
    .tdata   (m_axis_tdata),
    .blended (m_axis_tuser[0])
  );

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v == '1))
    else $error("input blocked while pipeline has room");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v[NS-2] && !free[NS-1]) |=> v[NS-2])
    else $error("item dropped from last lane stage during stall");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("output item changed while stalled");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for seam_linear_alpha_blend_top: drives pixel items, checks blended output.
// Depends on sla_pkg and the RTL top; predicts each result with its own feather-blend model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  localparam int MAX_W = 4096;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // first field in the lowest bits: declared last
  typedef struct packed {
    logic [7:0]  stitched_blue;
    logic [7:0]  stitched_green;
    logic [7:0]  stitched_red;
    logic [7:0]  right_blue;
    logic [7:0]  right_green;
    logic [7:0]  right_red;
    logic [7:0]  left_blue;
    logic [7:0]  left_green;
    logic [7:0]  left_red;
    logic [11:0] column;
  } pixel_t;

  typedef struct packed {
    logic       blended;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } blend_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LW_W-1:0] cfg_data = '0;

  // shadow of the block's registers
  logic [11:0] ov_start = '0;
  logic [11:0] ov_end = '0;
  logic [12:0] left_w = '0;

  pixel_t pixel_q[$];
  blend_res_t blend_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  seam_linear_alpha_blend_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] feather_channel(longint l, longint r, longint w, longint d);
    longint num;
    num = l * (w - d) + r * d;
    if (w < 0) begin
      num = -num;
      w = -w;
    end
    if (num <= 0) return 8'd0;
    num = num / w;
    return (num > 255) ? 8'd255 : num[7:0];
  endfunction

  function automatic blend_res_t blend_pixel(pixel_t p);
    blend_res_t res;
    longint w, d;
    int lw;
    lw = (left_w > MAX_W) ? MAX_W : int'(left_w);
    if (p.column >= ov_start && int'(p.column) < lw) begin
      w = longint'(ov_end) - longint'(ov_start);
      d = longint'(p.column) - longint'(ov_start);
      if ({p.right_red, p.right_green, p.right_blue} == '0 || w == 0) begin
        res.red = p.left_red;
        res.green = p.left_green;
        res.blue = p.left_blue;
      end else begin
        res.red = feather_channel(p.left_red, p.right_red, w, d);
        res.green = feather_channel(p.left_green, p.right_green, w, d);
        res.blue = feather_channel(p.left_blue, p.right_blue, w, d);
      end
      res.blended = 1'b1;
    end else begin
      res.red = p.stitched_red;
      res.green = p.stitched_green;
      res.blue = p.stitched_blue;
      res.blended = 1'b0;
    end
    return res;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        blend_q.insert(blend_q.size(), blend_pixel(pixel_q.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_TDATA_W'(pixel_q[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    blend_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata};
      if (blend_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected item: %h", got);
      end else begin
        want = blend_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.blended !== want.blended) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d bl=%0d, got r=%0d g=%0d b=%0d bl=%0d",
                     want.red, want.green, want.blue, want.blended,
                     got.red, got.green, got.blue, got.blended);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OVERLAP_START: ov_start = val[11:0];
      CFG_OVERLAP_END:   ov_end = val[11:0];
      CFG_LEFT_WIDTH:    left_w = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [LW_W-1:0] st, input logic [LW_W-1:0] en,
                              input logic [LW_W-1:0] lw);
    write_reg(CFG_OVERLAP_START, st);
    write_reg(CFG_OVERLAP_END, en);
    write_reg(CFG_LEFT_WIDTH, lw);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || blend_q.size() != 0) @(posedge clk);
  endtask

  // rgb args are {blue, green, red}
  task automatic push_px(input logic [11:0] col, input logic [23:0] l, input logic [23:0] r,
                         input logic [23:0] s);
    pixel_t p;
    p.column = col;
    {p.left_blue, p.left_green, p.left_red} = l;
    {p.right_blue, p.right_green, p.right_red} = r;
    {p.stitched_blue, p.stitched_green, p.stitched_red} = s;
    pixel_q.insert(pixel_q.size(), p);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int lw;
    lw = (left_w > MAX_W) ? MAX_W : int'(left_w);
    p = {rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
         rand_chan(), rand_chan(), rand_chan(), 12'd0};
    if ($urandom_range(9) == 0) {p.right_red, p.right_green, p.right_blue} = '0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: begin
        if (int'(ov_start) < lw) p.column = 12'($urandom_range(int'(ov_start), lw - 1));
        else p.column = 12'($urandom_range(4095));
      end
      7: p.column = ov_start + 12'($urandom_range(2)) - 12'd1;
      8: p.column = 12'(lw + $urandom_range(1) - 1);
      default: p.column = 12'($urandom_range(4095));
    endcase
    return p;
  endfunction

  initial begin
    int n;
    logic [LW_W-1:0] st, en, lw;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: left width zero, everything passes through
    @(negedge clk);
    push_px(12'd0, 24'hFFFFFF, 24'h123456, 24'hA5C3E1);
    push_px(12'd4095, 24'h000000, 24'hFFFFFF, 24'h5A3C1E);
    drain();

    set_geometry(13'd100, 13'd200, 13'd300);
    @(negedge clk);
    push_px(12'd99, 24'hFFFFFF, 24'hFFFFFF, 24'h010203);
    push_px(12'd100, 24'hFF00FF, 24'h00FF01, 24'h000000);
    push_px(12'd150, 24'hFF00FF, 24'h00FF01, 24'hFFFFFF);
    push_px(12'd150, 24'h804020, 24'h000000, 24'hFFFFFF);
    push_px(12'd199, 24'hFFFFFF, 24'h0000FF, 24'h000000);
    push_px(12'd200, 24'h00FF00, 24'hFF00FF, 24'h000000);
    push_px(12'd250, 24'h000000, 24'hFFFFFF, 24'h000000);
    push_px(12'd250, 24'hFFFFFF, 24'h010101, 24'h000000);
    push_px(12'd299, 24'h7F80FF, 24'h01FE00, 24'h000000);
    push_px(12'd300, 24'hFFFFFF, 24'hFFFFFF, 24'hC0FFEE);
    drain();

    // zero blend width
    write_reg(CFG_OVERLAP_END, 13'd100);
    @(negedge clk);
    push_px(12'd150, 24'h112233, 24'hFFFFFF, 24'h000000);
    drain();

    // end before start
    write_reg(CFG_OVERLAP_END, 13'd40);
    @(negedge clk);
    push_px(12'd120, 24'hFFFFFF, 24'h102030, 24'h000000);
    push_px(12'd299, 24'h102030, 24'hFFFFFF, 24'h000000);
    drain();

    // empty region, then a write to an unused index
    write_reg(CFG_OVERLAP_START, 13'd500);
    write_reg(CFG_SPARE_IDX, 13'h1FFF);
    @(negedge clk);
    push_px(12'd500, 24'hFFFFFF, 24'hFFFFFF, 24'h3C5A78);
    push_px(12'd299, 24'hFFFFFF, 24'hFFFFFF, 24'h87A5C3);
    drain();

    // left width above the maximum
    set_geometry(13'd0, 13'd4095, 13'h1FFF);
    @(negedge clk);
    push_px(12'd4095, 24'h000000, 24'hFFFFFF, 24'h000000);
    push_px(12'd0, 24'hFFFFFF, 24'h000000, 24'h000000);
    push_px(12'd2048, 24'hFF00FF, 24'h00FF00, 24'h000000);
    drain();

    // upper bits of start and end are dropped
    set_geometry(13'h1FFF, 13'h1000, 13'd4096);
    @(negedge clk);
    push_px(12'd4095, 24'hABCDEF, 24'h123456, 24'h000000);
    push_px(12'd4094, 24'hABCDEF, 24'h123456, 24'h777777);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin st = 13'd0; en = 13'd4095; lw = 13'd4096; end
        1: begin st = 13'd4095; en = 13'd0; lw = 13'h1FFF; end
        default: begin
          st = 13'($urandom_range(3000));
          en = 13'(int'(st) + $urandom_range(600));
          if ($urandom_range(3) == 0) en = 13'($urandom_range(4095));
          lw = 13'(int'(st) + $urandom_range(800));
          if ($urandom_range(4) == 0) lw = 13'($urandom_range(8191));
        end
      endcase
      set_geometry(st, en, lw);
      if (ph % 3 == 2) write_reg(CFG_SPARE_IDX, 13'($urandom_range(8191)));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      n = 75;
      @(negedge clk);
      for (int i = 0; i < n / 2; i++) pixel_q.insert(pixel_q.size(), rand_pixel());
      // hold off until the block is empty, then continue
      drain();
      @(negedge clk);
      for (int i = n / 2; i < n; i++) pixel_q.insert(pixel_q.size(), rand_pixel());
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && blend_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sla_pkg.sv
rtl/sla_front.sv
rtl/sla_lane.sv
rtl/sla_merge.sv
rtl/seam_linear_alpha_blend_top.sv
bench/tb_top.sv
